### sv/phh_pkg.sv
package phh_pkg;

  // Default geometry
  localparam int BIN_COUNT_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 14;
  localparam int COUNT_BITS_DEF  = 32;

  // Fixed field widths
  localparam int SCALE_W     = 24;
  localparam int IDX_W       = 10;
  localparam int BIN_W       = 10;
  localparam int OUT_COUNT_W = 32;

  // Q4.20 scale
  localparam int FRAC_BITS = 20;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd87381;

  // Queue depths
  localparam int DESC_DEPTH = 4;
  localparam int OUT_DEPTH  = 8;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  // One result beat
  typedef struct packed {
    kind_e                  kind;
    logic [BIN_W-1:0]       bin_a;
    logic                   hit_a;
    logic [BIN_W-1:0]       bin_b;
    logic                   hit_b;
    logic [OUT_COUNT_W-1:0] count_a;
    logic [OUT_COUNT_W-1:0] count_b;
  } res_t;

  // Width of a front-to-back descriptor: kind, two sums, read index
  function automatic int desc_bits(int sample_bits);
    return 1 + 2 * (sample_bits + 2) + IDX_W;
  endfunction

endpackage

### sv/phh_if.sv
// Input channel: sample pairs and read requests
interface phh_in_if #(
  parameter int SAMPLE_BITS = phh_pkg::SAMPLE_BITS_DEF
);
  import phh_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic                          last_sample;
  logic [IDX_W-1:0]              read_index;

  modport source (output valid, op, sample_a, sample_b, last_sample, read_index,
                  input ready);
  modport sink   (input valid, op, sample_a, sample_b, last_sample, read_index,
                  output ready);
endinterface

// Result channel
interface phh_out_if;
  import phh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [BIN_W-1:0]       bin_a;
  logic                   hit_a;
  logic [BIN_W-1:0]       bin_b;
  logic                   hit_b;
  logic [OUT_COUNT_W-1:0] count_a;
  logic [OUT_COUNT_W-1:0] count_b;

  modport source (output valid, kind, bin_a, hit_a, bin_b, hit_b, count_a, count_b,
                  input ready);
  modport sink   (input valid, kind, bin_a, hit_a, bin_b, hit_b, count_a, count_b,
                  output ready);
endinterface

// Configuration write channel (bin_scale)
interface phh_cfg_if;
  import phh_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] bin_scale;

  modport source (output valid, bin_scale, input ready);
  modport sink   (input valid, bin_scale, output ready);
endinterface

### sv/phh_queue.sv
module phh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import phh_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + PTR_W'(1);
      end
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  // Writers must respect the full flag; readers the empty flag
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

### sv/phh_ram.sv
module phh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; a colliding read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/phh_front.sv
module phh_front #(
  parameter int SAMPLE_BITS = phh_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  phh_in_if.sink                                     in_i,
  input  logic                                       clear_busy_i,
  input  logic                                       q_full_i,
  output logic                                       q_push_o,
  output logic [phh_pkg::desc_bits(SAMPLE_BITS)-1:0] q_data_o
);
  import phh_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] peak;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic                          await_right;
  } chan_t;

  typedef struct packed {
    kind_e                   kind;
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    logic [IDX_W-1:0]        read_index;
  } desc_t;

  // Peak tracking for one channel and one sample
  function automatic chan_t track(chan_t c, logic signed [SAMPLE_BITS-1:0] x,
                                  logic is_first, logic is_last);
    chan_t                   n;
    logic signed [SUM_W-1:0] xe;
    n  = c;
    xe = SUM_W'(x);
    if (is_first) begin
      n.peak        = x[SAMPLE_BITS-1] ? '0 : x;
      n.sum         = xe + xe;
      n.await_right = 1'b1;
    end else begin
      if (c.await_right) begin
        n.sum         = c.sum + xe;
        n.await_right = 1'b0;
      end
      // strictly greater: the first maximum wins
      if (x > c.peak) begin
        n.peak        = x;
        n.sum         = SUM_W'(c.prev) + xe;
        n.await_right = 1'b1;
      end
    end
    n.prev = x;
    // peak on the last sample: its own value stands in for the right neighbor
    if (is_last && n.await_right) begin
      n.sum         = n.sum + xe;
      n.await_right = 1'b0;
    end
    return n;
  endfunction

  chan_t ch_a_q, ch_b_q, ch_a_d, ch_b_d;
  logic  record_start_q;
  logic  accept, is_read;
  desc_t desc;

  assign in_i.ready = !clear_busy_i && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_read    = (in_i.op == OP_READ);

  assign ch_a_d = track(ch_a_q, in_i.sample_a, record_start_q, in_i.last_sample);
  assign ch_b_d = track(ch_b_q, in_i.sample_b, record_start_q, in_i.last_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_a_q         <= '0;
      ch_b_q         <= '0;
      record_start_q <= 1'b1;
    end else if (accept && !is_read) begin
      ch_a_q         <= ch_a_d;
      ch_b_q         <= ch_b_d;
      record_start_q <= in_i.last_sample;
    end
  end

  // Reads and record ends go to the back end
  always_comb begin
    desc.kind       = is_read ? KIND_READ : KIND_RECORD;
    desc.sum_a      = ch_a_d.sum;
    desc.sum_b      = ch_b_d.sum;
    desc.read_index = in_i.read_index;
  end

  assign q_push_o = accept && (is_read || in_i.last_sample);
  assign q_data_o = desc;

endmodule

### sv/phh_back.sv
module phh_back #(
  parameter int BIN_COUNT   = phh_pkg::BIN_COUNT_DEF,
  parameter int SAMPLE_BITS = phh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = phh_pkg::COUNT_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  phh_cfg_if.sink                                    cfg_i,
  phh_out_if.source                                  out_o,
  input  logic                                       q_empty_i,
  input  logic [phh_pkg::desc_bits(SAMPLE_BITS)-1:0] q_data_i,
  output logic                                       q_pop_o,
  output logic                                       clear_busy_o
);
  import phh_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int PW     = SUM_W + SCALE_W + 1;
  localparam int QW     = PW - FRAC_BITS;
  localparam int ADDR_W = $clog2(BIN_COUNT);
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int EXT_W  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam int OC_W   = $clog2(OUT_DEPTH+1);
  localparam logic signed [PW-1:0] ROUND = PW'(1) << (FRAC_BITS-1);

  typedef struct packed {
    kind_e                   kind;
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    logic [IDX_W-1:0]        read_index;
  } desc_t;

  typedef struct packed {
    logic              hit;
    logic [BIN_W-1:0]  bin;
    logic [ADDR_W-1:0] addr;
  } bin_t;

  // Round-half-up product to bin, truncated toward zero, range checked
  function automatic bin_t to_bin(logic signed [PW-1:0] t);
    bin_t          r;
    logic [PW-1:0] mag;
    logic [QW-1:0] qm;
    logic          neg;
    mag    = t[PW-1] ? PW'(-t) : PW'(t);
    qm     = mag[PW-1:FRAC_BITS];
    neg    = t[PW-1] && (qm != '0);
    r.addr = qm[ADDR_W-1:0];
    r.hit  = !neg && (qm < QW'(BIN_COUNT));
    if (neg) begin
      r.bin = '0;
    end else if (!r.hit) begin
      r.bin = BIN_W'(BIN_COUNT-1);
    end else begin
      r.bin = qm[BIN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] to_out(logic [COUNT_BITS-1:0] c);
    return OUT_COUNT_W'(EXT_W'(c));
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  // ---------------- configuration ----------------
  logic [SCALE_W-1:0] bin_scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_scale_q <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      bin_scale_q <= cfg_i.bin_scale;
    end
  end

  // ---------------- clearing pass ----------------
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == ADDR_W'(BIN_COUNT-1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
    end
  end

  assign clear_busy_o = clr_busy_q;

  // ---------------- issue: credit against the result queue ----------------
  desc_t            head;
  logic             s1_v_q, s2_v_q;
  logic [OC_W-1:0]  of_count;
  logic [OC_W:0]    outstanding;
  logic             of_full, of_empty;

  assign head        = q_data_i;
  assign outstanding = (OC_W+1)'(s1_v_q) + (OC_W+1)'(s2_v_q) + (OC_W+1)'(of_count);
  assign q_pop_o     = !clr_busy_q && !q_empty_i && (outstanding < (OC_W+1)'(OUT_DEPTH));

  // ---------------- stage 1: scale multiply and rounding add ----------------
  logic signed [SCALE_W:0] scale_s;
  logic signed [PW-1:0]    prod_a, prod_b;
  logic signed [PW-1:0]    s1_t_a_q, s1_t_b_q;
  kind_e                   s1_kind_q;
  logic [IDX_W-1:0]        s1_idx_q;

  assign scale_s = $signed({1'b0, bin_scale_q});
  assign prod_a  = head.sum_a * scale_s;
  assign prod_b  = head.sum_b * scale_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_t_a_q  <= prod_a + ROUND;
      s1_t_b_q  <= prod_b + ROUND;
      s1_kind_q <= head.kind;
      s1_idx_q  <= head.read_index;
    end
  end

  // ---------------- stage 2: bin, range check, histogram read ----------------
  bin_t              bin_a, bin_b;
  logic [CMP_W-1:0]  idx_ext;
  logic              idx_in_range;
  logic [ADDR_W-1:0] idx_addr, raddr_a, raddr_b;

  assign bin_a        = to_bin(s1_t_a_q);
  assign bin_b        = to_bin(s1_t_b_q);
  assign idx_ext      = CMP_W'(s1_idx_q);
  assign idx_in_range = (idx_ext < CMP_W'(BIN_COUNT));
  assign idx_addr     = idx_ext[ADDR_W-1:0];
  assign raddr_a      = (s1_kind_q == KIND_READ) ? idx_addr : bin_a.addr;
  assign raddr_b      = (s1_kind_q == KIND_READ) ? idx_addr : bin_b.addr;

  kind_e             s2_kind_q;
  logic              s2_hit_a_q, s2_hit_b_q, s2_in_range_q;
  logic [BIN_W-1:0]  s2_bin_a_q, s2_bin_b_q;
  logic [ADDR_W-1:0] s2_addr_a_q, s2_addr_b_q;
  logic [IDX_W-1:0]  s2_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_kind_q     <= s1_kind_q;
    s2_hit_a_q    <= bin_a.hit;
    s2_hit_b_q    <= bin_b.hit;
    s2_bin_a_q    <= bin_a.bin;
    s2_bin_b_q    <= bin_b.bin;
    s2_addr_a_q   <= raddr_a;
    s2_addr_b_q   <= raddr_b;
    s2_in_range_q <= idx_in_range;
    s2_idx_q      <= s1_idx_q;
  end

  // ---------------- stage 3: saturating increment and write back ----------------
  logic [COUNT_BITS-1:0] rd_a, rd_b, cur_a, cur_b, inc_a, inc_b;
  logic                  item_we_a, item_we_b;
  logic                  byp_v_a_q, byp_v_b_q;
  logic [ADDR_W-1:0]     byp_addr_a_q, byp_addr_b_q;
  logic [COUNT_BITS-1:0] byp_data_a_q, byp_data_b_q;
  logic                  we_a, we_b;
  logic [ADDR_W-1:0]     waddr_a, waddr_b;
  logic [COUNT_BITS-1:0] wdata_a, wdata_b;
  logic                  is_rec;

  // the write of the previous beat is not yet in the read data
  assign cur_a = (byp_v_a_q && (byp_addr_a_q == s2_addr_a_q)) ? byp_data_a_q : rd_a;
  assign cur_b = (byp_v_b_q && (byp_addr_b_q == s2_addr_b_q)) ? byp_data_b_q : rd_b;
  assign inc_a = sat_inc(cur_a);
  assign inc_b = sat_inc(cur_b);

  assign is_rec    = (s2_kind_q == KIND_RECORD);
  assign item_we_a = s2_v_q && is_rec && s2_hit_a_q;
  assign item_we_b = s2_v_q && is_rec && s2_hit_b_q;

  assign we_a    = clr_busy_q || item_we_a;
  assign we_b    = clr_busy_q || item_we_b;
  assign waddr_a = clr_busy_q ? clr_addr_q : s2_addr_a_q;
  assign waddr_b = clr_busy_q ? clr_addr_q : s2_addr_b_q;
  assign wdata_a = clr_busy_q ? '0 : inc_a;
  assign wdata_b = clr_busy_q ? '0 : inc_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_a_q <= 1'b0;
      byp_v_b_q <= 1'b0;
    end else begin
      byp_v_a_q <= item_we_a;
      byp_v_b_q <= item_we_b;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_addr_a_q <= s2_addr_a_q;
    byp_addr_b_q <= s2_addr_b_q;
    byp_data_a_q <= inc_a;
    byp_data_b_q <= inc_b;
  end

  phh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_hist_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  phh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_hist_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata_b),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  // ---------------- result beat ----------------
  res_t res, of_head;
  logic of_pop;

  always_comb begin
    res.kind = s2_kind_q;
    if (is_rec) begin
      res.bin_a   = s2_bin_a_q;
      res.hit_a   = s2_hit_a_q;
      res.bin_b   = s2_bin_b_q;
      res.hit_b   = s2_hit_b_q;
      res.count_a = s2_hit_a_q ? to_out(inc_a) : '0;
      res.count_b = s2_hit_b_q ? to_out(inc_b) : '0;
    end else begin
      res.bin_a   = s2_idx_q;
      res.hit_a   = 1'b0;
      res.bin_b   = s2_idx_q;
      res.hit_b   = 1'b0;
      res.count_a = s2_in_range_q ? to_out(cur_a) : '0;
      res.count_b = s2_in_range_q ? to_out(cur_b) : '0;
    end
  end

  assign of_pop = out_o.valid && out_o.ready;

  phh_queue #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q),
    .data_i  (res),
    .pop_i   (of_pop),
    .data_o  (of_head),
    .full_o  (of_full),
    .empty_o (of_empty),
    .count_o (of_count)
  );

  assign out_o.valid   = !of_empty;
  assign out_o.kind    = of_head.kind;
  assign out_o.bin_a   = of_head.bin_a;
  assign out_o.hit_a   = of_head.hit_a;
  assign out_o.bin_b   = of_head.bin_b;
  assign out_o.hit_b   = of_head.hit_b;
  assign out_o.count_a = of_head.count_a;
  assign out_o.count_b = of_head.count_b;

  // Credit check keeps the result queue from overflowing
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> !of_full) else $error("result beat with no queue space");
  // No beat may be in the pipe while the histograms are being cleared
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_v_q && !s2_v_q)) else $error("beat in flight during clear");
  // The clearing pass runs once
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q) else $error("clear restarted");

endmodule

### sv/pulse_height_histogram_top.sv
// Two-channel pulse-height analyzer. Sample-pair beats (op 0) track each
// channel's peak; the beat with last_sample set closes the record, its
// three-sample peak sum is scaled by bin_scale (Q4.20) into a bin, and that
// bin's saturating count is incremented, giving one result beat. Read beats
// (op 1) return both counts of read_index. One input beat is taken every
// clock while the descriptor queue has room: the front end does one compare
// per sample, and the back end, while the result queue has credit, does one
// read-modify-write per histogram per clock, forwarding the previous write.
// After reset the histograms are zeroed in a pass over all BIN_COUNT bins
// (1024 by default), one bin per clock, during which in_i.ready stays low;
// bin_scale writes are taken at any time but belong in idle periods.
module pulse_height_histogram_top #(
  parameter int BIN_COUNT   = phh_pkg::BIN_COUNT_DEF,
  parameter int SAMPLE_BITS = phh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = phh_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  phh_in_if.sink    in_i,
  phh_cfg_if.sink   cfg_i,
  phh_out_if.source out_o
);
  import phh_pkg::*;

  localparam int DESC_W = desc_bits(SAMPLE_BITS);

  logic              clear_busy;
  logic              q_push, q_pop, q_full, q_empty;
  logic [DESC_W-1:0] q_wdata, q_rdata;
  logic [$clog2(DESC_DEPTH+1)-1:0] q_count;

  phh_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // Descriptor queue between front and back
  phh_queue #(.WIDTH(DESC_W), .DEPTH(DESC_DEPTH)) u_desc_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  phh_back #(
    .BIN_COUNT   (BIN_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .out_o        (out_o),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .clear_busy_o (clear_busy)
  );

  // Queue occupancy tracks the flags
  a_q_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> (q_count != '0)) else $error("descriptor queue flags disagree");

endmodule
